// File: sv/bca_pkg.sv
// ----------------------------------------------------------------------------
// bca_pkg
// Shared types and constants for the bitmap cell allocator: field widths,
// action and status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package bca_pkg;

    // Default page size in cells
    localparam int CELLS_DEFAULT = 256;

    // Bitmap row width; the search looks at one row per cycle
    localparam int WORD_W  = 16;
    localparam int WORD_AW = $clog2(WORD_W);

    // Fixed field widths
    localparam int CNT_W  = 9;
    localparam int IDX_W  = 8;
    localparam int THR_W  = 7;
    localparam int STAT_W = 2;

    // Threshold after reset
    localparam logic [THR_W-1:0] THRESH_RESET = 7'd4;

    // Action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_DONE
    } bca_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the request
        logic check;     // decide early exits, apply free bookkeeping
        logic scan;      // examine one bitmap row
        logic mark_wr;   // write back one marked row
        logic out_load;  // move the result into the output register
    } bca_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic check_done;  // request ends without touching the bitmap
        logic check_scan;  // allocate goes on to the search
        logic scan_hit;    // run found in the current row
        logic scan_last;   // current row is the last one
        logic mark_last;   // current marked row ends the run
        logic out_free;    // output register can take a result
    } bca_stat_t;

endpackage

// File: sv/bitmap_cell_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_cell_allocator_core
// First-fit allocator for one page of fixed-size cells held in a bitmap.
// ----------------------------------------------------------------------------
// One request is handled at a time; one result is returned per request, and
// the next request is taken while the previous result waits in the output
// register. The bitmap is kept in 16-cell rows of a single-port memory, and
// that memory port sets the timing: a request that ends at the checks goes
// straight to the result; an allocate searches up to CELLS/16 rows, rounded
// up (16 for the default page), then marks each row that the run spans by a
// read and a write-back, and a free only marks its rows. The next request
// can be accepted in the cycle after the result is loaded. No clearing pass
// is needed after reset: each row has a valid bit and reads as all free
// until first written.
// ----------------------------------------------------------------------------
module bitmap_cell_allocator_core
#(
    parameter int CELLS = bca_pkg::CELLS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [8:0] cell_count, [16:9] start_index
    input  logic [0:0]  s_axis_tuser,   // [0] action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] cell_index
    output logic [2:0]  m_axis_tuser,   // [0] granted, [2:1] status
    // threshold register
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data     // full_threshold
);

    bca_pkg::bca_cmd_t  cmd;
    bca_pkg::bca_stat_t stat;
    logic               res_granted;
    logic [bca_pkg::IDX_W-1:0]  res_index;
    logic [bca_pkg::STAT_W-1:0] res_status;

    // Sequencer
    bca_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Bitmap, search and bookkeeping
    bca_datapath #(.CELLS(CELLS)) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_action  (s_axis_tuser[0]),
        .req_count   (s_axis_tdata[8:0]),
        .req_start   (s_axis_tdata[16:9]),
        .thr_wr_en   (cfg_wr_en),
        .thr_wr_data (cfg_wr_data),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_granted (res_granted),
        .res_index   (res_index),
        .res_status  (res_status),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Result packing
    assign m_axis_tdata = res_index;
    assign m_axis_tuser = {res_status, res_granted};

endmodule

// File: sv/bca_ctrl.sv
// ----------------------------------------------------------------------------
// bca_ctrl
// Sequencer for the allocator: request capture, checks, row-by-row search,
// read-modify-write marking of the run, and hand-off of the result.
// ----------------------------------------------------------------------------
module bca_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bca_pkg::bca_stat_t stat,
    output bca_pkg::bca_cmd_t  cmd
);

    bca_pkg::bca_state_t state_reg;
    bca_pkg::bca_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bca_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bca_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = bca_pkg::ST_CHECK;
                end
            end
            bca_pkg::ST_CHECK:
            begin
                if (stat.check_done)
                begin
                    state_next = bca_pkg::ST_DONE;
                end
                else if (stat.check_scan)
                begin
                    state_next = bca_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = bca_pkg::ST_MARK_RD;
                end
            end
            bca_pkg::ST_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    state_next = bca_pkg::ST_MARK_RD;
                end
                else if (stat.scan_last)
                begin
                    state_next = bca_pkg::ST_DONE;
                end
            end
            bca_pkg::ST_MARK_RD:
            begin
                state_next = bca_pkg::ST_MARK_WR;
            end
            bca_pkg::ST_MARK_WR:
            begin
                if (stat.mark_last)
                begin
                    state_next = bca_pkg::ST_DONE;
                end
                else
                begin
                    state_next = bca_pkg::ST_MARK_RD;
                end
            end
            bca_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = bca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bca_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            bca_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            bca_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            bca_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            bca_pkg::ST_MARK_RD:
            begin
                cmd = '0;
            end
            bca_pkg::ST_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
            end
            bca_pkg::ST_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/bca_datapath.sv
// ----------------------------------------------------------------------------
// bca_datapath
// Bitmap row memory, first-fit run search over one row per cycle, run
// marking, free-estimate bookkeeping, threshold register and output register.
// ----------------------------------------------------------------------------
module bca_datapath
#(
    parameter int CELLS = bca_pkg::CELLS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // request
    input  logic                           req_action,
    input  logic [bca_pkg::CNT_W-1:0]      req_count,
    input  logic [bca_pkg::IDX_W-1:0]      req_start,
    // threshold write
    input  logic                           thr_wr_en,
    input  logic [bca_pkg::THR_W-1:0]      thr_wr_data,
    // result
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic                           res_granted,
    output logic [bca_pkg::IDX_W-1:0]      res_index,
    output logic [bca_pkg::STAT_W-1:0]     res_status,
    // controller link
    input  bca_pkg::bca_cmd_t              cmd,
    output bca_pkg::bca_stat_t             stat
);

    localparam int WORD_W  = bca_pkg::WORD_W;
    localparam int WORD_AW = bca_pkg::WORD_AW;
    localparam int ROWS    = (CELLS + WORD_W - 1) / WORD_W;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int EST_W   = $clog2(CELLS + 1);
    localparam int CALC_W  = ((EST_W > bca_pkg::CNT_W + 1) ? EST_W : bca_pkg::CNT_W + 1) + 1;
    localparam logic [CALC_W-1:0] CELLS_C = CALC_W'(CELLS);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);

    // Request capture
    logic                         action_reg;
    logic [bca_pkg::CNT_W-1:0]    count_reg;
    logic [bca_pkg::IDX_W-1:0]    first_reg;

    // Page bookkeeping
    logic [EST_W-1:0]             est_reg;
    logic                         full_reg;
    logic [bca_pkg::THR_W-1:0]    thr_reg;

    // Search and marking
    logic [ROW_W-1:0]             scan_row_reg;
    logic [CALC_W-1:0]            carry_reg;
    logic [CALC_W-1:0]            mark_first_reg;
    logic [CALC_W-1:0]            mark_last_reg;
    logic [ROW_W-1:0]             mark_row_reg;
    logic                         mark_set_reg;

    // Pending result
    logic                         pend_granted_reg;
    logic [bca_pkg::IDX_W-1:0]    pend_index_reg;
    logic [bca_pkg::STAT_W-1:0]   pend_status_reg;

    // Output register
    logic                         out_valid_reg;
    logic                         out_granted_reg;
    logic [bca_pkg::IDX_W-1:0]    out_index_reg;
    logic [bca_pkg::STAT_W-1:0]   out_status_reg;

    // Bitmap rows
    logic [WORD_W-1:0]            mem [ROWS];
    logic [ROWS-1:0]              row_valid_reg;
    logic [WORD_W-1:0]            mem_q_reg;
    logic                         rd_valid_reg;
    logic [ROW_W-1:0]             rd_addr;
    logic [WORD_W-1:0]            word;

    // Arithmetic views
    logic [CALC_W-1:0]            count_w;
    logic [CALC_W-1:0]            first_w;
    logic [CALC_W-1:0]            est_w;
    logic [CALC_W-1:0]            thr_w;
    logic [CALC_W-1:0]            est_alloc;
    logic [CALC_W-1:0]            est_fail;
    logic [CALC_W-1:0]            est_sum;
    logic [CALC_W-1:0]            est_sat;
    logic                         is_zero;
    logic                         alloc_range;
    logic                         free_range;
    logic                         no_room;

    // Row search
    logic [CALC_W-1:0]            scan_base;
    logic [WORD_W-1:0]            used;
    logic [CALC_W-1:0]            run [WORD_W];
    logic [WORD_W-1:0]            hit;
    logic                         hit_any;
    logic [WORD_AW-1:0]           hit_pos;
    logic [CALC_W-1:0]            last_pos;
    logic [CALC_W-1:0]            start_pos;
    logic                         have_used;
    logic [WORD_AW-1:0]           last_used;

    // Row marking
    logic [CALC_W-1:0]            mark_base;
    logic [WORD_W-1:0]            mark_mask;
    logic [WORD_W-1:0]            mark_data;

    // Decisions
    logic                         do_free;
    logic                         do_hit;
    logic                         do_fail;
    logic                         do_early;

    // Arithmetic on the captured request
    always_comb
    begin
        count_w     = CALC_W'(count_reg);
        first_w     = CALC_W'(first_reg);
        est_w       = CALC_W'(est_reg);
        thr_w       = CALC_W'(thr_reg);
        est_alloc   = est_w - count_w;
        est_fail    = count_w - CALC_W'(1);
        est_sum     = est_w + count_w;
        est_sat     = (est_sum > CELLS_C) ? CELLS_C : est_sum;
        is_zero     = (count_reg == '0);
        alloc_range = (count_w > CELLS_C);
        free_range  = ((first_w + count_w) > CELLS_C);
        no_room     = full_reg || (est_w < count_w);
    end

    // Row read: word 0 on entry to the search, next row while searching,
    // current mark row otherwise
    always_comb
    begin
        if (cmd.check)
        begin
            rd_addr = '0;
        end
        else if (cmd.scan)
        begin
            rd_addr = (scan_row_reg == LAST_ROW) ? '0 : scan_row_reg + ROW_W'(1);
        end
        else
        begin
            rd_addr = mark_row_reg;
        end
    end

    // Rows never written read as all free
    assign word = rd_valid_reg ? mem_q_reg : '0;

    // Run length ending at each bit of the row, carried over from lower rows
    always_comb
    begin
        have_used = 1'b0;
        last_used = '0;
        hit_any   = 1'b0;
        hit_pos   = '0;
        scan_base = CALC_W'(scan_row_reg) << WORD_AW;
        for (int j = 0; j < WORD_W; j++)
        begin
            // cells past the page end count as used
            used[j] = word[j] || ((scan_base + CALC_W'(j)) >= CELLS_C);
        end
        for (int j = 0; j < WORD_W; j++)
        begin
            have_used = 1'b0;
            last_used = '0;
            for (int k = 0; k < WORD_W; k++)
            begin
                if (k <= j && used[k])
                begin
                    have_used = 1'b1;
                    last_used = WORD_AW'(k);
                end
            end
            if (used[j])
            begin
                run[j] = '0;
            end
            else if (have_used)
            begin
                run[j] = CALC_W'(j) - CALC_W'(last_used);
            end
            else
            begin
                run[j] = carry_reg + CALC_W'(j + 1);
            end
            hit[j] = !used[j] && (run[j] >= count_w);
        end
        // lowest hit
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (hit[j])
            begin
                hit_any = 1'b1;
                hit_pos = WORD_AW'(j);
            end
        end
        last_pos  = scan_base + CALC_W'(hit_pos);
        start_pos = last_pos + CALC_W'(1) - count_w;
    end

    // Set or clear the run's bits in the current mark row
    always_comb
    begin
        mark_base = CALC_W'(mark_row_reg) << WORD_AW;
        for (int j = 0; j < WORD_W; j++)
        begin
            mark_mask[j] = ((mark_base + CALC_W'(j)) >= mark_first_reg) &&
                           ((mark_base + CALC_W'(j)) <= mark_last_reg);
        end
        mark_data = mark_set_reg ? (word | mark_mask) : (word & ~mark_mask);
    end

    // Decisions taken this cycle
    always_comb
    begin
        do_early = cmd.check && (is_zero ||
                   ((action_reg == bca_pkg::ACT_ALLOC) ? (alloc_range || no_room)
                                                       : free_range));
        do_free  = cmd.check && !is_zero && (action_reg == bca_pkg::ACT_FREE) && !free_range;
        do_hit   = cmd.scan && hit_any;
        do_fail  = cmd.scan && !hit_any && (scan_row_reg == LAST_ROW);
    end

    // Status to controller
    always_comb
    begin
        stat.check_done = is_zero ||
                          ((action_reg == bca_pkg::ACT_ALLOC) ? (alloc_range || no_room)
                                                              : free_range);
        stat.check_scan = !is_zero && (action_reg == bca_pkg::ACT_ALLOC) &&
                          !alloc_range && !no_room;
        stat.scan_hit   = hit_any;
        stat.scan_last  = (scan_row_reg == LAST_ROW);
        stat.mark_last  = (mark_row_reg == mark_last_reg[ROW_W+WORD_AW-1:WORD_AW]);
        stat.out_free   = !out_valid_reg || res_ready;
    end

    // Bitmap memory
    always_ff @(posedge clk)
    begin
        if (cmd.mark_wr)
        begin
            mem[mark_row_reg] <= mark_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.mark_wr)
            begin
                row_valid_reg[mark_row_reg] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    // Page state and threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg  <= EST_W'(CELLS);
            full_reg <= 1'b0;
            thr_reg  <= bca_pkg::THRESH_RESET;
        end
        else
        begin
            if (thr_wr_en)
            begin
                thr_reg <= thr_wr_data;
            end
            if (do_free)
            begin
                est_reg <= est_sat[EST_W-1:0];
                if (est_w < thr_w && est_sat >= thr_w)
                begin
                    full_reg <= 1'b0;
                end
            end
            else if (do_hit)
            begin
                est_reg <= est_alloc[EST_W-1:0];
                if (est_alloc < thr_w)
                begin
                    full_reg <= 1'b1;
                end
            end
            else if (do_fail)
            begin
                est_reg <= est_fail[EST_W-1:0];
                if (est_fail < thr_w)
                begin
                    full_reg <= 1'b1;
                end
            end
        end
    end

    // Request, search and mark registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= req_action;
            count_reg  <= req_count;
            first_reg  <= req_start;
        end
        if (cmd.check)
        begin
            scan_row_reg <= '0;
            carry_reg    <= '0;
        end
        else if (cmd.scan)
        begin
            scan_row_reg <= scan_row_reg + ROW_W'(1);
            carry_reg    <= run[WORD_W-1];
        end
        if (do_free)
        begin
            mark_first_reg <= first_w;
            mark_last_reg  <= first_w + count_w - CALC_W'(1);
            mark_row_reg   <= first_w[ROW_W+WORD_AW-1:WORD_AW];
            mark_set_reg   <= 1'b0;
        end
        else if (do_hit)
        begin
            mark_first_reg <= start_pos;
            mark_last_reg  <= last_pos;
            mark_row_reg   <= start_pos[ROW_W+WORD_AW-1:WORD_AW];
            mark_set_reg   <= 1'b1;
        end
        else if (cmd.mark_wr)
        begin
            mark_row_reg <= mark_row_reg + ROW_W'(1);
        end
    end

    // Pending result
    always_ff @(posedge clk)
    begin
        if (do_early)
        begin
            pend_granted_reg <= 1'b0;
            pend_index_reg   <= '0;
            if (is_zero)
            begin
                pend_status_reg <= bca_pkg::STAT_ZERO;
            end
            else if (action_reg == bca_pkg::ACT_ALLOC && !alloc_range)
            begin
                pend_status_reg <= bca_pkg::STAT_NO_ROOM;
            end
            else
            begin
                pend_status_reg <= bca_pkg::STAT_RANGE;
            end
        end
        else if (do_free)
        begin
            pend_granted_reg <= 1'b1;
            pend_index_reg   <= '0;
            pend_status_reg  <= bca_pkg::STAT_OK;
        end
        else if (do_hit)
        begin
            pend_granted_reg <= 1'b1;
            pend_index_reg   <= start_pos[bca_pkg::IDX_W-1:0];
            pend_status_reg  <= bca_pkg::STAT_OK;
        end
        else if (do_fail)
        begin
            pend_granted_reg <= 1'b0;
            pend_index_reg   <= '0;
            pend_status_reg  <= bca_pkg::STAT_NO_ROOM;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_granted_reg <= pend_granted_reg;
            out_index_reg   <= pend_index_reg;
            out_status_reg  <= pend_status_reg;
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_granted = out_granted_reg;
    assign res_index   = out_index_reg;
    assign res_status  = out_status_reg;

endmodule
